// ===== rtl/ddsdac_pkg.sv =====
// Shared types, constants and the sine table builder for the dual sine converter framer.
package ddsdac_pkg;

  localparam int unsigned PHASE_BITS_DEFAULT      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEFAULT = 8;

  localparam int unsigned CFG_INDEX_BITS = 4;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP_ONE = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP_TWO = 4'd1;

  localparam logic [7:0]  CMD_A        = 8'h18;
  localparam logic [7:0]  CMD_B        = 8'h19;
  localparam logic [15:0] RESTORE_ZERO = 16'h0000;
  localparam logic [15:0] RESTORE_ONE  = 16'h4000;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_DC    = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic        target_chip;
    logic        target_channel;
    logic [15:0] dc_code;
  } in_item_t;

  typedef struct packed {
    logic        chip_select;
    logic [7:0]  command_byte;
    logic [15:0] sample_value;
    logic        last_frame;
  } out_item_t;

  // (a * b) >> 62, kept to 64 bits. Only ever evaluated while building the table.
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned quotient by shift and subtract. Only ever evaluated while building the table.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi/2 * k / quarter) in Q46, quarter being a quarter of the table depth.
  function automatic logic [63:0] quarter_sine_q46(int unsigned k, int unsigned addr_bits);
    logic [63:0] quarter;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] den;
    int unsigned n;
    quarter = 64'd1 << (addr_bits - 2);
    if (k == 0) begin
      return 64'd0;
    end
    if (64'(k) >= quarter) begin
      return 64'd1 << 46;
    end
    x = (HALF_PI_Q62 >> (addr_bits - 2)) * 64'(k)
        + (((HALF_PI_Q62 & (quarter - 64'd1)) * 64'(k)) >> (addr_bits - 2));
    x2 = mul_q62(x, x);
    term = x;
    sum = x;
    for (n = 1; n <= 12; n++) begin
      den = 64'((2 * n) * (2 * n + 1));
      term = udiv64(mul_q62(term, x2), den);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + (64'd1 << 15)) >> 16;
    if (r > (64'd1 << 46)) begin
      r = 64'd1 << 46;
    end
    return r;
  endfunction

  // One table entry: floor(32767.5 + 32767.5 * sin(2*pi*i/depth)), exact.
  function automatic logic [15:0] sine_rom_entry(int unsigned i, int unsigned addr_bits);
    logic [63:0] quarter;
    logic [1:0]  quad;
    logic [63:0] k;
    logic [63:0] s;
    logic [63:0] a;
    logic [63:0] c;
    logic [63:0] v;
    quarter = 64'd1 << (addr_bits - 2);
    quad = 2'((64'(i) >> (addr_bits - 2)) & 64'd3);
    k = 64'(i) & (quarter - 64'd1);
    if (quad[0]) begin
      k = quarter - k;
    end
    s = quarter_sine_q46(32'(k), addr_bits);
    a = 64'd65535 * s;
    if (!quad[1]) begin
      v = 64'd32767 + ((a + (64'd1 << 46)) >> 47);
    end else begin
      c = 64'd0;
      if (a > (64'd1 << 46)) begin
        c = (a - (64'd1 << 46) + (64'd1 << 47) - 64'd1) >> 47;
      end
      v = 64'd32767 - c;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/ddsdac_sine_rom.sv =====
// Sine lookup table with two registered read ports.
module ddsdac_sine_rom #(
  parameter int unsigned ADDR_BITS = ddsdac_pkg::TABLE_ADDR_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ADDR_BITS-1:0] addr_one,
  input  logic [ADDR_BITS-1:0] addr_two,
  output logic [15:0]          data_one,
  output logic [15:0]          data_two
);
  import ddsdac_pkg::*;

  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic [15:0] rom_tab [Depth];

  // Every entry is a constant worked out at elaboration.
  for (genvar g = 0; g < Depth; g++) begin : g_entry
    localparam logic [15:0] Entry = sine_rom_entry(g, ADDR_BITS);
    assign rom_tab[g] = Entry;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_one <= rom_tab[addr_one];
      data_two <= rom_tab[addr_two];
    end
  end

endmodule

// ===== rtl/dual_dds_sine_dac_framer.sv =====
// Top level of the dual sine generator that frames samples for two dual-channel converters.
//
// Each accepted item is a tick, a start, a stop or a DC write, and the block answers with
// 24-bit converter frames (chip select, command byte, 16 data bits), the final frame of an
// item flagged by last_frame. Phase, running flag and sine lookup are all settled in the
// cycle an item is accepted; the item then sits in a single job register while a frame
// counter walks it out through one output register, one frame per cycle unless the
// output stalls. A tick while running or a stop while running therefore sends four frames,
// a DC write five frames when it also stops the generators and one frame otherwise, and
// items that give no frames (start, tick or stop while idle) leave the job register empty.
// Each frame is built from the job register and then held in the output register. The
// next item is accepted in the same cycle as the last frame of the current one is loaded,
// so ticks offered back to back leave no gap between their frames. Phase step registers
// may be written at any time the block is idle and take effect on the next tick; writes
// to any other index are ignored, and the write port is always ready.
module dual_dds_sine_dac_framer #(
  parameter int unsigned PHASE_BITS      = ddsdac_pkg::PHASE_BITS_DEFAULT,
  parameter int unsigned TABLE_ADDR_BITS = ddsdac_pkg::TABLE_ADDR_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ddsdac_pkg::in_item_t                  in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ddsdac_pkg::out_item_t                 out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ddsdac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ddsdac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ddsdac_pkg::*;

  // Frame positions within a job: 0..3 form the four-frame group, 4 is the DC frame.
  localparam logic [2:0] FRAME_FIRST      = 3'd0;
  localparam logic [2:0] FRAME_GROUP_LAST = 3'd3;
  localparam logic [2:0] FRAME_DC         = 3'd4;

  // What one accepted item still has to send.
  typedef struct packed {
    logic        group;       // four-frame group present (tick or restore)
    logic        tick;        // group carries samples rather than restore codes
    logic        dc;          // closing DC frame present
    logic        dc_chip;
    logic        dc_channel;
    logic [15:0] dc_code;
  } job_t;

  // Architectural state
  logic [PHASE_BITS-1:0] phase_step_one;
  logic [PHASE_BITS-1:0] phase_step_two;
  logic [PHASE_BITS-1:0] phase_one;
  logic [PHASE_BITS-1:0] phase_two;
  logic                  running;

  // Job and output stages
  logic       job_valid;
  job_t       job;
  logic [2:0] idx;

  logic [PHASE_BITS-1:0] phase_one_next;
  logic [PHASE_BITS-1:0] phase_two_next;
  logic                  running_next;
  logic                  job_load;
  job_t                  job_next;
  logic [2:0]            idx_start;

  logic        accept_in;
  logic        frame_go;
  logic        frame_last;
  logic        job_done;
  logic [15:0] sample_one;
  logic [15:0] sample_two;
  out_item_t   frame;

  // The write port never holds off a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step_one <= '0;
      phase_step_two <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP_ONE: phase_step_one <= cfg_data[PHASE_BITS-1:0];
        REG_PHASE_STEP_TWO: phase_step_two <= cfg_data[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input side: an item may enter whenever the job register is empty or is sending its
  // final frame in this cycle.
  assign frame_go   = job_valid && (!out_valid || !out_stall);
  assign frame_last = (idx == (job.dc ? FRAME_DC : FRAME_GROUP_LAST));
  assign job_done   = frame_go && frame_last;
  assign in_stall   = job_valid && !job_done;
  assign accept_in  = in_valid && !in_stall;

  // Decode of one item: state update and the job it leaves behind.
  always_comb begin
    phase_one_next      = phase_one;
    phase_two_next      = phase_two;
    running_next        = running;
    job_load            = 1'b0;
    job_next.group      = 1'b0;
    job_next.tick       = 1'b0;
    job_next.dc         = 1'b0;
    job_next.dc_chip    = in_item.target_chip;
    job_next.dc_channel = in_item.target_channel;
    job_next.dc_code    = in_item.dc_code;
    case (in_item.func)
      FUNC_TICK: begin
        if (running) begin
          phase_one_next = phase_one + phase_step_one;
          phase_two_next = phase_two + phase_step_two;
          job_load       = 1'b1;
          job_next.group = 1'b1;
          job_next.tick  = 1'b1;
        end
      end
      FUNC_START: begin
        if (!running) begin
          phase_one_next = '0;
          phase_two_next = '0;
          running_next   = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (running) begin
          running_next   = 1'b0;
          job_load       = 1'b1;
          job_next.group = 1'b1;
        end
      end
      FUNC_DC: begin
        // A DC write stops a running generator first, restore frames and all.
        running_next   = 1'b0;
        job_load       = 1'b1;
        job_next.group = running;
        job_next.dc    = 1'b1;
      end
      default: ;
    endcase
    idx_start = job_next.group ? FRAME_FIRST : FRAME_DC;
  end

  // The table is read with the new phases, so its registered output lines up with the job.
  ddsdac_sine_rom #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk      (clk),
    .en       (accept_in),
    .addr_one (phase_one_next[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .addr_two (phase_two_next[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .data_one (sample_one),
    .data_two (sample_two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_one <= '0;
      phase_two <= '0;
      running   <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (accept_in) begin
        phase_one <= phase_one_next;
        phase_two <= phase_two_next;
        running   <= running_next;
        job_valid <= job_load;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      job <= job_next;
      idx <= idx_start;
    end else if (frame_go) begin
      idx <= idx + 3'd1;
    end
  end

  // Frame builder. Within the group, bit 1 of the position picks the chip and bit 0 the
  // converter channel.
  always_comb begin
    if (idx == FRAME_DC) begin
      frame.chip_select  = job.dc_chip;
      frame.command_byte = job.dc_channel ? CMD_B : CMD_A;
      frame.sample_value = job.dc_code;
    end else begin
      frame.chip_select  = idx[1];
      frame.command_byte = idx[0] ? CMD_B : CMD_A;
      if (job.tick) begin
        frame.sample_value = idx[1] ? sample_two : sample_one;
      end else begin
        frame.sample_value = idx[1] ? RESTORE_ONE : RESTORE_ZERO;
      end
    end
    frame.last_frame = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_go) begin
      out_item <= frame;
    end
  end

  // The final frame of a job is the one that goes out flagged.
  a_last_flagged: assert property (@(posedge clk) disable iff (rst)
    job_done |=> out_valid && out_item.last_frame)
    else $error("final frame of a job not flagged");

  a_mid_unflagged: assert property (@(posedge clk) disable iff (rst)
    (frame_go && !frame_last) |=> out_valid && !out_item.last_frame && job_valid)
    else $error("frame flagged last before the job was finished");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (idx <= FRAME_DC) && (job.group || idx == FRAME_DC))
    else $error("frame position outside its job");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (accept_in && in_item.func == FUNC_START) |=> running)
    else $error("start did not leave the generators running");

  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (accept_in && (in_item.func == FUNC_STOP || in_item.func == FUNC_DC)) |=> !running)
    else $error("stop or DC write left the generators running");

endmodule
